// ----- hdl/fcs_pkg.sv -----
package fcs_pkg;

    localparam int TABLE_BYTES   = 8192;
    localparam int TABLE_AW      = $clog2(TABLE_BYTES);
    localparam int CLUSTER_BYTES = 512;
    localparam int CLUSTER_SHIFT = $clog2(CLUSTER_BYTES);
    localparam int OFFSET_W      = 21;
    localparam int SKIP_W        = OFFSET_W - CLUSTER_SHIFT;
    localparam int TABLE_AT_W    = 14;

    localparam logic [11:0] LINK_MASK = 12'hFFF;
    localparam logic [11:0] LINK_MIN  = 12'h002;
    localparam logic [11:0] LINK_MAX  = 12'hFF7;

    localparam logic [15:0] DATA_OFFSET_RST = 16'd31;
    localparam logic [7:0]  SPC_RST         = 8'd1;
    localparam logic [12:0] BPS_RST         = 13'd512;

    localparam logic [1:0] CFG_DATA_OFFSET = 2'd0;
    localparam logic [1:0] CFG_SPC         = 2'd1;
    localparam logic [1:0] CFG_BPS         = 2'd2;

    localparam logic ACT_LOAD = 1'b0;
    localparam logic ACT_SEEK = 1'b1;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_LINK,
        ST_RD_HI,
        ST_DECODE,
        ST_MUL1,
        ST_MUL2,
        ST_DONE
    } fcs_state_t;

    typedef struct packed {
        logic en;
        logic second;
    } fcs_mul_ctrl_t;

endpackage

// ----- hdl/fat12_chain_seek_top.sv -----
// FAT12 cluster chain walker over an internal allocation table of 8192 bytes.
// Input channel (in_valid / in_stall): action 0 loads table_byte_value at
// table_byte_address and gives no result; action 1 seeks from start_cluster
// to file_offset and gives one result on the output channel.
// Output channel (out_valid / out_stall): cluster_reached, disk_address,
// chain_broken and steps_taken of one seek per transaction.
// Configuration (cfg_valid / cfg_ready, cfg_index, cfg_data): index 0 is
// data_offset, 1 sectors_per_cluster, 2 bytes_per_sector; other indexes are
// ignored. Writes are meant for idle periods only.
// After reset the table is cleared one byte a cycle, and in_stall stays high
// until every byte is cleared; configuration writes are taken during that time.
// A load leaves the walker idle, so the next load or seek can be taken at once.
// A seek follows its links one by one: each link needs two byte reads
// through the single table read port plus a decode step, and the disk
// address takes two passes through one shared multiplier.
// A finished result waits in the output register while out_stall is high;
// the walker then holds its result and keeps in_stall high, while loads
// and seeks are taken again once the result register is free.
module fat12_chain_seek_top (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic        action,
    input  logic [12:0] table_byte_address,
    input  logic [7:0]  table_byte_value,
    input  logic [11:0] start_cluster,
    input  logic [20:0] file_offset,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [11:0] cluster_reached,
    output logic [31:0] disk_address,
    output logic        chain_broken,
    output logic [11:0] steps_taken,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data
);
    import fcs_pkg::*;

    logic [15:0] data_offset_reg;
    logic [7:0]  spc_reg;
    logic [12:0] bps_reg;
    logic        out_valid_reg;
    logic [11:0] cluster_out_reg;
    logic [31:0] address_out_reg;
    logic        broken_out_reg;
    logic [11:0] steps_out_reg;

    logic        out_free;
    logic        result_load;
    logic [11:0] res_cluster;
    logic [31:0] res_address;
    logic        res_broken;
    logic [11:0] res_steps;

    assign cfg_ready = 1'b1;
    assign out_free  = !out_valid_reg || !out_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            data_offset_reg <= DATA_OFFSET_RST;
            spc_reg         <= SPC_RST;
            bps_reg         <= BPS_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                CFG_DATA_OFFSET: data_offset_reg <= cfg_data;
                CFG_SPC:         spc_reg         <= cfg_data[7:0];
                CFG_BPS:         bps_reg         <= cfg_data[12:0];
                default:         ;
            endcase
        end
    end

    fcs_seq u_seq (
        .clk                (clk),
        .rst_n              (rst_n),
        .in_valid           (in_valid),
        .in_stall           (in_stall),
        .action             (action),
        .table_byte_address (table_byte_address),
        .table_byte_value   (table_byte_value),
        .start_cluster      (start_cluster),
        .file_offset        (file_offset),
        .data_offset        (data_offset_reg),
        .sectors_per_cluster(spc_reg),
        .bytes_per_sector   (bps_reg),
        .out_free           (out_free),
        .result_load        (result_load),
        .res_cluster        (res_cluster),
        .res_address        (res_address),
        .res_broken         (res_broken),
        .res_steps          (res_steps)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (result_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (result_load)
        begin
            cluster_out_reg <= res_cluster;
            address_out_reg <= res_address;
            broken_out_reg  <= res_broken;
            steps_out_reg   <= res_steps;
        end
    end

    assign out_valid       = out_valid_reg;
    assign cluster_reached = cluster_out_reg;
    assign disk_address    = address_out_reg;
    assign chain_broken    = broken_out_reg;
    assign steps_taken     = steps_out_reg;

endmodule

// ----- hdl/fcs_ram.sv -----
module fcs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ----- hdl/fcs_mul_unit.sv -----
module fcs_mul_unit (
    input  logic                  clk,
    input  fcs_pkg::fcs_mul_ctrl_t ctrl,
    input  logic [15:0]           data_offset,
    input  logic [11:0]           cluster,
    input  logic [7:0]            sectors_per_cluster,
    input  logic [12:0]           bytes_per_sector,
    input  logic [8:0]            cluster_off,
    output logic [31:0]           acc
);
    import fcs_pkg::*;

    logic [31:0] acc_reg;
    logic [31:0] acc_next;
    logic [24:0] op_a;
    logic [12:0] op_b;
    logic [37:0] product;

    // First pass forms the cluster base in sectors, which always fits 25 bits;
    // the second scales it to bytes and adds the offset within the cluster.
    always_comb
    begin
        if (ctrl.second)
        begin
            op_a = acc_reg[24:0];
            op_b = bytes_per_sector;
        end
        else
        begin
            op_a = 25'(data_offset) + 25'(cluster);
            op_b = 13'(sectors_per_cluster);
        end
        product  = 38'(op_a) * 38'(op_b);
        acc_next = product[31:0] + (ctrl.second ? 32'(cluster_off) : 32'd0);
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.en)
        begin
            acc_reg <= acc_next;
        end
    end

    assign acc = acc_reg;

endmodule

// ----- hdl/fcs_seq.sv -----
module fcs_seq (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic        action,
    input  logic [12:0] table_byte_address,
    input  logic [7:0]  table_byte_value,
    input  logic [11:0] start_cluster,
    input  logic [20:0] file_offset,
    input  logic [15:0] data_offset,
    input  logic [7:0]  sectors_per_cluster,
    input  logic [12:0] bytes_per_sector,
    input  logic        out_free,
    output logic        result_load,
    output logic [11:0] res_cluster,
    output logic [31:0] res_address,
    output logic        res_broken,
    output logic [11:0] res_steps
);
    import fcs_pkg::*;

    fcs_state_t            state_reg, state_next;
    logic [TABLE_AW-1:0]   clr_cnt_reg, clr_cnt_next;
    logic [11:0]           cluster_reg, cluster_next;
    logic [SKIP_W-1:0]     skip_reg, skip_next;
    logic [CLUSTER_SHIFT-1:0] within_reg, within_next;
    logic [11:0]           steps_reg, steps_next;
    logic                  broken_reg, broken_next;
    logic [7:0]            lo_byte_reg, lo_byte_next;
    logic                  rd_ok_reg, rd_ok_next;

    logic                  accept;
    logic                  ram_we;
    logic [TABLE_AW-1:0]   ram_waddr;
    logic [7:0]            ram_wdata;
    logic [TABLE_AW-1:0]   ram_raddr;
    logic [7:0]            ram_rdata;
    logic [7:0]            rd_byte;
    logic [TABLE_AT_W-1:0] at_addr;
    logic [TABLE_AT_W-1:0] rd_addr;
    logic [15:0]           word;
    logic [11:0]           link;
    fcs_mul_ctrl_t         mul_ctrl;
    logic [31:0]           mul_acc;

    assign in_stall = (state_reg != ST_IDLE);
    assign accept   = in_valid && !in_stall;

    // Entry of the link for cluster c sits at byte c + c/2.
    assign at_addr = TABLE_AT_W'(cluster_reg) + TABLE_AT_W'(cluster_reg[11:1]);
    assign rd_addr = (state_reg == ST_RD_HI) ? at_addr + TABLE_AT_W'(1) : at_addr;
    assign ram_raddr = TABLE_AW'(rd_addr);

    assign rd_byte = rd_ok_reg ? ram_rdata : 8'd0;
    assign word    = {rd_byte, lo_byte_reg};
    assign link    = (cluster_reg[0] ? word[15:4] : word[11:0]) & LINK_MASK;

    always_comb
    begin
        if (state_reg == ST_CLEAR)
        begin
            ram_we    = 1'b1;
            ram_waddr = clr_cnt_reg;
            ram_wdata = 8'd0;
        end
        else
        begin
            ram_we    = accept && (action == ACT_LOAD)
                        && (32'(table_byte_address) < TABLE_BYTES);
            ram_waddr = TABLE_AW'(table_byte_address);
            ram_wdata = table_byte_value;
        end
    end

    fcs_ram #(
        .WIDTH(8),
        .DEPTH(TABLE_BYTES)
    ) u_table (
        .clk  (clk),
        .we   (ram_we),
        .waddr(ram_waddr),
        .wdata(ram_wdata),
        .raddr(ram_raddr),
        .rdata(ram_rdata)
    );

    fcs_mul_unit u_mul (
        .clk                (clk),
        .ctrl               (mul_ctrl),
        .data_offset        (data_offset),
        .cluster            (cluster_reg),
        .sectors_per_cluster(sectors_per_cluster),
        .bytes_per_sector   (bytes_per_sector),
        .cluster_off        (within_reg),
        .acc                (mul_acc)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_CLEAR;
            clr_cnt_reg <= '0;
        end
        else
        begin
            state_reg   <= state_next;
            clr_cnt_reg <= clr_cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cluster_reg <= cluster_next;
        skip_reg    <= skip_next;
        within_reg  <= within_next;
        steps_reg   <= steps_next;
        broken_reg  <= broken_next;
        lo_byte_reg <= lo_byte_next;
        rd_ok_reg   <= rd_ok_next;
    end

    always_comb
    begin
        state_next    = state_reg;
        clr_cnt_next  = clr_cnt_reg;
        cluster_next  = cluster_reg;
        skip_next     = skip_reg;
        within_next   = within_reg;
        steps_next    = steps_reg;
        broken_next   = broken_reg;
        lo_byte_next  = lo_byte_reg;
        rd_ok_next    = rd_ok_reg;
        mul_ctrl      = '0;
        result_load   = 1'b0;

        unique case (state_reg)
            ST_CLEAR:
            begin
                clr_cnt_next = clr_cnt_reg + TABLE_AW'(1);
                if (clr_cnt_reg == TABLE_AW'(TABLE_BYTES - 1))
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (accept && (action == ACT_SEEK))
                begin
                    cluster_next = start_cluster;
                    skip_next    = file_offset[OFFSET_W-1:CLUSTER_SHIFT];
                    within_next  = file_offset[CLUSTER_SHIFT-1:0];
                    steps_next   = '0;
                    broken_next  = 1'b0;
                    state_next   = ST_LINK;
                end
            end
            ST_LINK:
            begin
                if (steps_reg == 12'(skip_reg))
                begin
                    state_next = ST_MUL1;
                end
                else
                begin
                    rd_ok_next = (32'(rd_addr) < TABLE_BYTES);
                    state_next = ST_RD_HI;
                end
            end
            ST_RD_HI:
            begin
                lo_byte_next = rd_byte;
                rd_ok_next   = (32'(rd_addr) < TABLE_BYTES);
                state_next   = ST_DECODE;
            end
            ST_DECODE:
            begin
                // Free, reserved and end-of-chain markers end the walk early.
                if ((link < LINK_MIN) || (link > LINK_MAX))
                begin
                    broken_next = 1'b1;
                    state_next  = ST_MUL1;
                end
                else
                begin
                    cluster_next = link;
                    steps_next   = steps_reg + 12'd1;
                    state_next   = ST_LINK;
                end
            end
            ST_MUL1:
            begin
                mul_ctrl.en     = 1'b1;
                mul_ctrl.second = 1'b0;
                state_next      = ST_MUL2;
            end
            ST_MUL2:
            begin
                mul_ctrl.en     = 1'b1;
                mul_ctrl.second = 1'b1;
                state_next      = ST_DONE;
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    result_load = 1'b1;
                    state_next  = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign res_cluster = cluster_reg;
    assign res_address = mul_acc;
    assign res_broken  = broken_reg;
    assign res_steps   = steps_reg;

endmodule

// ----- hdl/fat12_chain_seek_chk.sv -----
module fat12_chain_seek_chk (
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_stall,
    input logic        action,
    input logic        out_valid,
    input logic        out_stall,
    input logic [31:0] disk_address
);
    import fcs_pkg::*;

    // A held result stays offered.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid)
        else $error("result withdrawn while stalled");

    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> $stable(disk_address))
        else $error("stalled result changed");

    // A seek occupies the walker, so the input must stall straight after it.
    a_seek_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall && (action == ACT_SEEK) |=> in_stall)
        else $error("input not stalled after a seek transaction");

    // A load never produces a result.
    a_load_silent: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall && (action == ACT_LOAD) && !out_valid |=> !out_valid)
        else $error("result appeared after a load");

endmodule

bind fat12_chain_seek_top fat12_chain_seek_chk u_chk (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .action      (action),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .disk_address(disk_address)
);
